// ===== design/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// bse_pkg: shared types and constants of the Bezier surface evaluator
// Grid geometry, fixed-point widths, command and register codes, transaction
// structs and the rounding and saturation helpers.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int MaxOrder = 8;
  localparam int IdxW     = $clog2(MaxOrder);
  localparam int AddrW    = 2 * IdxW;
  localparam int Depth    = MaxOrder * MaxOrder;
  localparam int CoordW   = 32;
  localparam int GridW    = 3 * CoordW;
  localparam int ParW     = 16;
  localparam int WtW      = 16;
  localparam int CfgW     = 4;
  localparam int BinW     = 6;
  localparam int MulAW    = 38;
  localparam int MulBW    = 18;
  localparam int ProdW    = MulAW + MulBW;

  localparam logic [ParW-1:0] ParOne = 16'h8000;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdEval = 1'b1;

  localparam logic CfgRows = 1'b0;
  localparam logic CfgCols = 1'b1;

  localparam logic [CfgW-1:0] OrderReset = 4'd4;

  // Pascal's triangle, row = degree, zero beyond the diagonal
  localparam logic [BinW-1:0] BinomTab [MaxOrder][MaxOrder] = '{
    '{1, 0,  0,  0,  0,  0, 0, 0},
    '{1, 1,  0,  0,  0,  0, 0, 0},
    '{1, 2,  1,  0,  0,  0, 0, 0},
    '{1, 3,  3,  1,  0,  0, 0, 0},
    '{1, 4,  6,  4,  1,  0, 0, 0},
    '{1, 5, 10, 10,  5,  1, 0, 0},
    '{1, 6, 15, 20, 15,  6, 1, 0},
    '{1, 7, 21, 35, 35, 21, 7, 1}
  };

  typedef struct packed {
    logic                     cmd;
    logic [IdxW-1:0]          grid_row;
    logic [IdxW-1:0]          grid_col;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic [ParW-1:0]          u_param;
    logic [ParW-1:0]          v_param;
  } bse_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic signed [CoordW-1:0] du_x;
    logic signed [CoordW-1:0] du_y;
    logic signed [CoordW-1:0] du_z;
    logic signed [CoordW-1:0] dv_x;
    logic signed [CoordW-1:0] dv_y;
    logic signed [CoordW-1:0] dv_z;
  } bse_out_t;

  typedef struct packed {
    logic signed [MulAW-1:0] a;
    logic signed [MulBW-1:0] b;
  } bse_mul_req_t;

  // floor((x + 2^14) / 2^15)
  function automatic logic signed [ProdW-1:0] round15(input logic signed [ProdW-1:0] x);
    logic signed [ProdW-1:0] s;
    s = x + $signed(ProdW'(16384));
    return s >>> 15;
  endfunction

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [ProdW-1:0] x);
    logic signed [ProdW-1:0] hi;
    logic signed [ProdW-1:0] lo;
    hi = $signed(ProdW'(32'h7fff_ffff));
    lo = -hi - $signed(ProdW'(1));
    if (x > hi) begin
      return $signed(32'h7fff_ffff);
    end else if (x < lo) begin
      return $signed(32'h8000_0000);
    end
    return x[CoordW-1:0];
  endfunction

endpackage

// ===== design/bse_ram.sv =====
// ----------------------------------------------------------------------------
// bse_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bse_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/bse_mul.sv =====
// ----------------------------------------------------------------------------
// bse_mul: shared signed multiplier
// One signed product a*b per cycle, registered.
// ----------------------------------------------------------------------------
module bse_mul (
  input  logic                             clk_i,
  input  bse_pkg::bse_mul_req_t            req_i,
  output logic signed [bse_pkg::ProdW-1:0] prod_o
);
  import bse_pkg::*;

  always_ff @(posedge clk_i) begin
    prod_o <= req_i.a * req_i.b;
  end

endmodule

// ===== design/bse_ctrl.sv =====
// ----------------------------------------------------------------------------
// bse_ctrl: evaluation sequencer
// Builds power and Bernstein weight tables, then walks the grid for the point
// and both derivatives, driving the shared multiplier and the grid RAM.
// ----------------------------------------------------------------------------
module bse_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             eval_i,
  input  logic [bse_pkg::ParW-1:0]         u_i,
  input  logic [bse_pkg::ParW-1:0]         v_i,
  input  logic [bse_pkg::IdxW-1:0]         deg_u_i,
  input  logic [bse_pkg::IdxW-1:0]         deg_v_i,
  input  logic [bse_pkg::GridW-1:0]        rdata_i,
  output logic [bse_pkg::AddrW-1:0]        raddr_o,
  output bse_pkg::bse_mul_req_t            mul_o,
  input  logic signed [bse_pkg::ProdW-1:0] prod_i,
  output logic                             busy_o,
  output logic                             done_o,
  output bse_pkg::bse_out_t                result_o
);
  import bse_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_POW_M, S_POW_W, S_WT_M1, S_WT_M2, S_WT_W,
    S_RDP, S_RDQ, S_MULV, S_ACCV, S_MULU, S_ACCU, S_FIN, S_SCL_W
  } state_e;

  localparam logic [1:0] KindPos = 2'd0;
  localparam logic [1:0] KindDu  = 2'd1;
  localparam logic [1:0] KindDv  = 2'd2;
  localparam logic [1:0] LastSet = 2'd3;
  localparam logic [1:0] LastAxis = 2'd2;
  localparam logic [IdxW-1:0] LastK = IdxW'(MaxOrder - 1);

  state_e state_q;
  logic [1:0]      set_q, kind_q, axis_q;
  logic [IdxW-1:0] k_q, i_q, j_q, n_q, m_q;
  logic            done_q;

  logic [ParW-1:0]          u_q, v_q;
  logic [WtW-1:0]           pw_q [4][MaxOrder];
  logic [WtW-1:0]           wt_q [4][MaxOrder];
  logic signed [CoordW-1:0] p_q;
  logic signed [ProdW-1:0]  row_q, total_q;
  logic signed [CoordW-1:0] res_q [3][3];

  logic [ParW-1:0]          t_sel, t_inv;
  logic [IdxW-1:0]          d_sel, ilim, jlim;
  logic [1:0]               pu_set, pf_set, wu_set, wv_set;
  logic signed [CoordW-1:0] axis_word;
  logic signed [CoordW:0]   val;
  logic signed [ProdW-1:0]  row_r, total_r;
  logic                     sum_init, adv, last_pass;

  assign t_sel  = set_q[1] ? v_q : u_q;
  assign t_inv  = ParOne - t_sel;
  assign pu_set = {set_q[1], 1'b0};
  assign pf_set = {set_q[1], 1'b1};

  always_comb begin
    case (set_q)
      2'd0:    d_sel = n_q;
      2'd1:    d_sel = n_q - 1'b1;
      2'd2:    d_sel = m_q;
      default: d_sel = m_q - 1'b1;
    endcase
  end

  assign ilim   = (kind_q == KindDu) ? n_q - 1'b1 : n_q;
  assign jlim   = (kind_q == KindDv) ? m_q - 1'b1 : m_q;
  assign wu_set = (kind_q == KindDu) ? 2'd1 : 2'd0;
  assign wv_set = (kind_q == KindDv) ? 2'd3 : 2'd2;

  always_comb begin
    case (axis_q)
      2'd0:    axis_word = rdata_i[CoordW-1:0];
      2'd1:    axis_word = rdata_i[2*CoordW-1:CoordW];
      default: axis_word = rdata_i[3*CoordW-1:2*CoordW];
    endcase
  end

  // point itself, or forward difference to the neighbour
  assign val = (kind_q == KindPos) ? {p_q[CoordW-1], p_q}
                                   : {axis_word[CoordW-1], axis_word} - {p_q[CoordW-1], p_q};

  assign row_r   = round15(row_q);
  assign total_r = round15(total_q);

  always_comb begin
    if (state_q == S_RDP) begin
      raddr_o = {i_q, j_q};
    end else if (kind_q == KindDu) begin
      raddr_o = {i_q + 1'b1, j_q};
    end else begin
      raddr_o = {i_q, j_q + 1'b1};
    end
  end

  always_comb begin
    mul_o = '0;
    case (state_q)
      S_POW_M: begin
        mul_o.a = $signed(MulAW'(pw_q[set_q][k_q - 1'b1]));
        mul_o.b = $signed(MulBW'(set_q[0] ? t_inv : t_sel));
      end
      S_WT_M1: begin
        mul_o.a = $signed(MulAW'(pw_q[pu_set][i_q]));
        mul_o.b = $signed(MulBW'(pw_q[pf_set][d_sel - i_q]));
      end
      S_WT_M2: begin
        mul_o.a = prod_i[MulAW-1:0];
        mul_o.b = $signed(MulBW'(BinomTab[d_sel][i_q]));
      end
      S_MULV: begin
        mul_o.a = MulAW'(val);
        mul_o.b = $signed(MulBW'(wt_q[wv_set][j_q]));
      end
      S_MULU: begin
        mul_o.a = row_r[MulAW-1:0];
        mul_o.b = $signed(MulBW'(wt_q[wu_set][i_q]));
      end
      S_FIN: begin
        mul_o.a = total_r[MulAW-1:0];
        mul_o.b = $signed(MulBW'((kind_q == KindDu) ? n_q : m_q));
      end
      default: mul_o = '0;
    endcase
  end

  assign sum_init  = (state_q == S_WT_W) && (i_q == d_sel) && (set_q == LastSet);
  assign adv       = ((state_q == S_FIN) && (kind_q == KindPos)) || (state_q == S_SCL_W);
  assign last_pass = (axis_q == LastAxis) && (kind_q == KindDv);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      set_q   <= '0;
      kind_q  <= '0;
      axis_q  <= '0;
      k_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      n_q     <= '0;
      m_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= adv && last_pass;
      case (state_q)
        S_IDLE: begin
          if (eval_i) begin
            n_q     <= deg_u_i;
            m_q     <= deg_v_i;
            set_q   <= '0;
            k_q     <= IdxW'(1);
            state_q <= S_POW_M;
          end
        end
        S_POW_M: state_q <= S_POW_W;
        S_POW_W: begin
          if (k_q == LastK) begin
            k_q <= IdxW'(1);
            if (set_q == LastSet) begin
              set_q   <= '0;
              i_q     <= '0;
              state_q <= S_WT_M1;
            end else begin
              set_q   <= set_q + 1'b1;
              state_q <= S_POW_M;
            end
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_POW_M;
          end
        end
        S_WT_M1: state_q <= S_WT_M2;
        S_WT_M2: state_q <= S_WT_W;
        S_WT_W: begin
          if (i_q == d_sel) begin
            i_q <= '0;
            if (set_q == LastSet) begin
              kind_q  <= KindPos;
              axis_q  <= '0;
              j_q     <= '0;
              state_q <= S_RDP;
            end else begin
              set_q   <= set_q + 1'b1;
              state_q <= S_WT_M1;
            end
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_WT_M1;
          end
        end
        S_RDP:  state_q <= S_RDQ;
        S_RDQ:  state_q <= S_MULV;
        S_MULV: state_q <= S_ACCV;
        S_ACCV: begin
          if (j_q == jlim) begin
            state_q <= S_MULU;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_RDP;
          end
        end
        S_MULU: state_q <= S_ACCU;
        S_ACCU: begin
          j_q <= '0;
          if (i_q == ilim) begin
            state_q <= S_FIN;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_RDP;
          end
        end
        S_FIN: begin
          if (kind_q != KindPos) begin
            state_q <= S_SCL_W;
          end
        end
        default: ;
      endcase

      // advance to the next axis, then the next kind; stop after the last
      if (adv) begin
        i_q     <= '0;
        j_q     <= '0;
        state_q <= last_pass ? S_IDLE : S_RDP;
        if (axis_q == LastAxis) begin
          axis_q <= '0;
          kind_q <= kind_q + 1'b1;
        end else begin
          axis_q <= axis_q + 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && eval_i) begin
      u_q <= (u_i > ParOne) ? ParOne : u_i;
      v_q <= (v_i > ParOne) ? ParOne : v_i;
      for (int s = 0; s < 4; s++) begin
        pw_q[s][0] <= ParOne;
      end
    end
    if (state_q == S_POW_W) begin
      pw_q[set_q][k_q] <= WtW'(round15(prod_i));
    end
    if (state_q == S_WT_W) begin
      wt_q[set_q][i_q] <= WtW'(round15(prod_i));
    end
    if (state_q == S_RDQ) begin
      p_q <= axis_word;
    end
    if (state_q == S_ACCV) begin
      row_q <= row_q + prod_i;
    end
    if (state_q == S_ACCU) begin
      total_q <= total_q + prod_i;
    end
    if (sum_init || state_q == S_ACCU) begin
      row_q <= '0;
    end
    if (sum_init || adv) begin
      total_q <= '0;
    end
    if (state_q == S_FIN && kind_q == KindPos) begin
      res_q[kind_q][axis_q] <= sat32(total_r);
    end
    if (state_q == S_SCL_W) begin
      res_q[kind_q][axis_q] <= sat32(prod_i);
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  assign result_o.pos_x = res_q[0][0];
  assign result_o.pos_y = res_q[0][1];
  assign result_o.pos_z = res_q[0][2];
  assign result_o.du_x  = res_q[1][0];
  assign result_o.du_y  = res_q[1][1];
  assign result_o.du_z  = res_q[1][2];
  assign result_o.dv_x  = res_q[2][0];
  assign result_o.dv_y  = res_q[2][1];
  assign result_o.dv_z  = res_q[2][2];

endmodule

// ===== design/bezier_surface_evaluator.sv =====
// ----------------------------------------------------------------------------
// bezier_surface_evaluator: tensor-product Bezier surface evaluator
// Holds the control grid and the order registers; evaluates the surface
// point and both partial derivatives in Q16.16 with saturation.
// ----------------------------------------------------------------------------
// A transaction is accepted at a rising edge with start_i high and busy_o
// low. A load transaction (cmd = 0) writes one control point in that single
// cycle and leaves busy_o low, so loads may follow back to back. An evaluate
// transaction (cmd = 1) raises busy_o and runs a sequencer around one shared
// multiplier and the single read port of the grid RAM: it builds the power
// tables, then the Bernstein weights, then walks the grid terms row by row
// for each of the nine sums. The result appears on result_o with done_o
// high for exactly one cycle and is not held: the receiver must take it
// then, it cannot stall. Order registers are to be written only while the
// block is idle, through cfg_we_i / cfg_idx_i / cfg_data_i; the block itself
// does not enforce this. Orders below 2 act as 2 and above 8 as 8. Grid
// entries read before being loaded give undefined results.
// ----------------------------------------------------------------------------
module bezier_surface_evaluator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  bse_pkg::bse_in_t          in_i,
  output logic                      busy_o,
  output logic                      done_o,
  output bse_pkg::bse_out_t         result_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [bse_pkg::CfgW-1:0]  cfg_data_i
);
  import bse_pkg::*;

  logic [CfgW-1:0]         rows_q, cols_q;
  logic [IdxW-1:0]         deg_u, deg_v;
  logic                    accept, load_we, eval_go;
  logic [AddrW-1:0]        raddr;
  logic [GridW-1:0]        rdata;
  bse_mul_req_t            mul_req;
  logic signed [ProdW-1:0] prod;

  // order registers, reset to 4 by 4
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= OrderReset;
      cols_q <= OrderReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgRows) begin
        rows_q <= cfg_data_i;
      end else begin
        cols_q <= cfg_data_i;
      end
    end
  end

  // clamp order to 2..MaxOrder and drop one to get the degree
  function automatic logic [IdxW-1:0] to_degree(input logic [CfgW-1:0] ord);
    if (ord < CfgW'(2)) begin
      return IdxW'(1);
    end else if (ord > CfgW'(MaxOrder)) begin
      return IdxW'(MaxOrder - 1);
    end
    return IdxW'(ord - 1'b1);
  endfunction

  assign deg_u = to_degree(rows_q);
  assign deg_v = to_degree(cols_q);

  assign accept  = start_i && !busy_o;
  assign load_we = accept && (in_i.cmd == CmdLoad);
  assign eval_go = accept && (in_i.cmd == CmdEval);

  // grid word packs x in the low lane, then y, then z
  bse_ram #(
    .Width (GridW),
    .Depth (Depth)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i ({in_i.grid_row, in_i.grid_col}),
    .wdata_i ({in_i.point_z, in_i.point_y, in_i.point_x}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bse_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  bse_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .eval_i   (eval_go),
    .u_i      (in_i.u_param),
    .v_i      (in_i.v_param),
    .deg_u_i  (deg_u),
    .deg_v_i  (deg_v),
    .rdata_i  (rdata),
    .raddr_o  (raddr),
    .mul_o    (mul_req),
    .prod_i   (prod),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // an evaluate always occupies the block; a load never does
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_go |=> busy_o) else $error("evaluate did not raise busy");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_we |=> !busy_o) else $error("load raised busy");

  // a result only closes a busy period, and lasts one cycle
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result without evaluation");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");

endmodule
